/* src/sams_pkg.sv */
// Shared types and constants for the shared-array multi-stack unit.
package sams_pkg;

   // Field widths fixed by the request and response formats
   localparam int STACK_COUNT_W = 4;
   localparam int STACK_ID_W    = 4;
   localparam int VALUE_W       = 32;
   localparam int STATUS_W      = 2;

   localparam logic [STACK_COUNT_W-1:0] STACK_COUNT_RESET = 4'd8;

   // Request commands
   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   // Response status codes
   typedef logic [STATUS_W-1:0] status_type;
   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_INVALID   = 2'd1;
   localparam status_type STATUS_OVERFLOW  = 2'd2;
   localparam status_type STATUS_UNDERFLOW = 2'd3;

   // Value returned by a pop that fails
   localparam logic [VALUE_W-1:0] POP_ERR_VALUE = 32'h8000_0000;

   // Sequencer states
   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOKUP,
      S_POP_READ
   } state_type;

   // Free-list update for one request
   typedef struct packed {
      logic take;
      logic give;
   } fl_op_type;

endpackage

/* src/sams_req_if.sv */
// Request channel: command, stack number and value to push.
interface sams_req_if;
   import sams_pkg::*;

   logic                       valid;
   logic                       ready;
   logic                       command;
   logic [STACK_ID_W-1:0]      stack_id;
   logic signed [VALUE_W-1:0]  push_value;

   modport source (output valid, output command, output stack_id, output push_value,
                   input ready);
   modport sink   (input valid, input command, input stack_id, input push_value,
                   output ready);
endinterface

/* src/sams_rsp_if.sv */
// Response channel: status and popped value.
interface sams_rsp_if;
   import sams_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [STATUS_W-1:0]        status;
   logic signed [VALUE_W-1:0]  pop_value;

   modport source (output valid, output status, output pop_value, input ready);
   modport sink   (input valid, input status, input pop_value, output ready);
endinterface

/* src/sams_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module sams_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

/* src/sams_free_list.sv */
// Free-list head and fresh-entry watermark; entries at or above the
// watermark were never taken and their successor is taken to be i+1.
module sams_free_list #(
   parameter int CAPACITY = 64,
   localparam int LINK_W = $clog2(CAPACITY + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sams_pkg::fl_op_type   op,
   input  logic [LINK_W-1:0]     link_in,
   output logic [LINK_W-1:0]     head,
   output logic                  head_fresh
);
   import sams_pkg::*;

   logic [LINK_W-1:0] head_ff, head_in;
   logic [LINK_W-1:0] fresh_ff, fresh_in;

   assign head_fresh = (head_ff >= fresh_ff);
   assign head       = head_ff;

   // take: head moves to its successor; give: returned entry becomes head
   always_comb begin
      head_in  = head_ff;
      fresh_in = fresh_ff;
      if (op.take) begin
         if (head_fresh) begin
            head_in  = head_ff + LINK_W'(1);
            fresh_in = head_ff + LINK_W'(1);
         end else begin
            head_in = link_in;
         end
      end else if (op.give) begin
         head_in = link_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         fresh_ff <= '0;
      end else begin
         head_ff  <= head_in;
         fresh_ff <= fresh_in;
      end
   end
endmodule

/* src/shared_array_multi_stack_unit.sv */
// A push or any error response is loaded into the response register from the
// lookup state, a good pop from the pop-read state after it; either waits
// there while the output register is full. A new request is taken only in idle.
// A finished response may wait in the output register while the next
// request is taken. Reset is synchronous: the stack count goes to 8, every
// stack empties and the free list restarts at entry 0.
module shared_array_multi_stack_unit #(
   parameter int CAPACITY   = 64,
   parameter int MAX_STACKS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [sams_pkg::STACK_COUNT_W-1:0]   csr_write_data,
   sams_req_if.sink                             req_bus,
   sams_rsp_if.source                           rsp_bus
);
   import sams_pkg::*;

   localparam int LINK_W   = $clog2(CAPACITY + 1);
   localparam int ENTRY_AW = $clog2(CAPACITY);
   localparam int SLOT_AW  = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
   localparam int ENTRY_W  = VALUE_W + LINK_W;
   localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(CAPACITY);

   state_type                 state_ff, state_in;
   logic [STACK_COUNT_W-1:0]  stack_count_ff;

   // Request held while it is worked on
   logic                      cmd_ff;
   logic [VALUE_W-1:0]        value_ff;
   logic                      invalid_ff;
   logic                      top_valid_rd_ff;
   logic [LINK_W-1:0]         entry_ff, entry_in;
   logic [SLOT_AW-1:0]        slot_ff;

   logic [MAX_STACKS-1:0]     top_valid_ff;

   // Response register
   logic                      rsp_valid_ff;
   status_type                rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0]        rsp_value_ff, rsp_value_in;
   logic                      rsp_load;

   logic                      req_accept;
   logic                      out_free;
   logic                      req_invalid;

   // Store ports
   logic                      top_we;
   logic [LINK_W-1:0]         top_wdata, top_rdata;
   logic                      entry_we, entry_re;
   logic [ENTRY_AW-1:0]       entry_waddr, entry_raddr;
   logic [ENTRY_W-1:0]        entry_wdata, entry_rdata;

   // Free list
   fl_op_type                 fl_op;
   logic [LINK_W-1:0]         fl_link, fl_head;
   logic                      fl_head_fresh;

   logic [LINK_W-1:0]         top_link_raw, top_link;
   logic [LINK_W-1:0]         ent_link_raw, ent_link;
   logic [VALUE_W-1:0]        ent_value;
   logic                      head_nil;

   assign req_accept    = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE);
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;

   // Id check against min(stack_count, MAX_STACKS)
   assign req_invalid = (32'(req_bus.stack_id) >= 32'(stack_count_ff)) ||
                        (32'(req_bus.stack_id) >= 32'(MAX_STACKS));

   // Stack top store; unwritten slots read as empty through the valid bits
   sams_ram #(.WIDTH(LINK_W), .DEPTH(MAX_STACKS)) u_top_ram (
      .clock (clock),
      .we    (top_we),
      .waddr (slot_ff),
      .wdata (top_wdata),
      .re    (req_accept),
      .raddr (SLOT_AW'(req_bus.stack_id)),
      .rdata (top_rdata)
   );

   // Entry store: value and link side by side
   sams_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_entry_ram (
      .clock (clock),
      .we    (entry_we),
      .waddr (entry_waddr),
      .wdata (entry_wdata),
      .re    (entry_re),
      .raddr (entry_raddr),
      .rdata (entry_rdata)
   );

   sams_free_list #(.CAPACITY(CAPACITY)) u_free_list (
      .clock      (clock),
      .reset      (reset),
      .op         (fl_op),
      .link_in    (fl_link),
      .head       (fl_head),
      .head_fresh (fl_head_fresh)
   );

   // Decode read data; any link at or above capacity is null
   assign top_link_raw = top_valid_rd_ff ? top_rdata : NIL_LINK;
   assign top_link     = (top_link_raw >= NIL_LINK) ? NIL_LINK : top_link_raw;
   assign ent_link_raw = fl_head_fresh && (state_ff == S_LOOKUP) ?
                         fl_head + LINK_W'(1) : entry_rdata[LINK_W-1:0];
   assign ent_link     = (ent_link_raw >= NIL_LINK) ? NIL_LINK : ent_link_raw;
   assign ent_value    = entry_rdata[ENTRY_W-1:LINK_W];
   assign head_nil     = (fl_head >= NIL_LINK);

   // Sequencer: read stores, then write back and load the response
   always_comb begin
      state_in      = state_ff;
      top_we        = 1'b0;
      top_wdata     = fl_head;
      entry_we      = 1'b0;
      entry_waddr   = fl_head[ENTRY_AW-1:0];
      entry_wdata   = {value_ff, top_link};
      entry_re      = 1'b0;
      entry_raddr   = fl_head[ENTRY_AW-1:0];
      entry_in      = entry_ff;
      fl_op         = '0;
      fl_link       = ent_link;
      rsp_load      = 1'b0;
      rsp_status_in = STATUS_OK;
      rsp_value_in  = '0;
      unique case (state_ff)
         S_IDLE: begin
            // read the free-list head entry along with the stack top
            if (req_accept) begin
               entry_re = 1'b1;
               state_in = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            if (cmd_ff == CMD_PUSH) begin
               if (out_free) begin
                  rsp_load = 1'b1;
                  state_in = S_IDLE;
                  if (invalid_ff) begin
                     rsp_status_in = STATUS_INVALID;
                  end else if (head_nil) begin
                     rsp_status_in = STATUS_OVERFLOW;
                  end else begin
                     entry_we  = 1'b1;
                     top_we    = 1'b1;
                     fl_op.take = 1'b1;
                  end
               end
            end else if (invalid_ff || (top_link == NIL_LINK)) begin
               if (out_free) begin
                  rsp_load      = 1'b1;
                  rsp_value_in  = POP_ERR_VALUE;
                  rsp_status_in = invalid_ff ? STATUS_INVALID : STATUS_UNDERFLOW;
                  state_in      = S_IDLE;
               end
            end else begin
               // fetch the top entry for the pop
               entry_re    = 1'b1;
               entry_raddr = top_link[ENTRY_AW-1:0];
               entry_in    = top_link;
               state_in    = S_POP_READ;
            end
         end
         S_POP_READ: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_value_in  = ent_value;
               entry_we      = 1'b1;
               entry_waddr   = entry_ff[ENTRY_AW-1:0];
               entry_wdata   = {ent_value, fl_head};
               top_we        = 1'b1;
               top_wdata     = ent_link;
               fl_op.give    = 1'b1;
               fl_link       = entry_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         stack_count_ff <= STACK_COUNT_RESET;
         rsp_valid_ff   <= 1'b0;
         top_valid_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            stack_count_ff <= csr_write_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (top_we) begin
            top_valid_ff[slot_ff] <= 1'b1;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff          <= req_bus.command;
         slot_ff         <= SLOT_AW'(req_bus.stack_id);
         value_ff        <= req_bus.push_value;
         invalid_ff      <= req_invalid;
         top_valid_rd_ff <= top_valid_ff[SLOT_AW'(req_bus.stack_id)];
      end
      entry_ff <= entry_in;
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_value_ff  <= rsp_value_in;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.status    = rsp_status_ff;
   assign rsp_bus.pop_value = $signed(rsp_value_ff);
endmodule

/* src/sams_checker.sv */
// Port-level checker for the multi-stack unit, with its bind.
module sams_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          req_command,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [sams_pkg::STATUS_W-1:0] rsp_status,
   input logic [sams_pkg::VALUE_W-1:0]  rsp_pop_value
);
   import sams_pkg::*;

   logic       acc, dlv;
   logic [1:0] count_ff, count_in;
   logic       q0_ff, q1_ff;
   logic       q0_in, q1_in;

   assign acc      = req_valid && req_ready;
   assign dlv      = rsp_valid && rsp_ready;
   assign count_in = count_ff + {1'b0, acc} - {1'b0, dlv};

   // Commands of requests still owed a response, oldest in q0
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_comb begin
      q0_in = q0_ff;
      q1_in = q1_ff;
      if (dlv) begin
         q0_in = q1_ff;
      end
      if (acc) begin
         if ((count_ff - {1'b0, dlv}) == 2'd0) begin
            q0_in = req_command;
         end else begin
            q1_in = req_command;
         end
      end
   end

   always_ff @(posedge clock) begin
      q0_ff <= q0_in;
      q1_ff <= q1_in;
   end

   // No response without an owed request
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (count_ff != 2'd0))
      else $error("response without outstanding request");

   // At most one request in work plus one waiting response
   a_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("too many outstanding requests");

   // Push responses carry zero and never underflow
   a_push_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (count_ff != 2'd0) && (q0_ff == CMD_PUSH)) |->
      ((rsp_pop_value == '0) && (rsp_status != STATUS_UNDERFLOW)))
      else $error("bad push response");

   // Failed pops carry the error value and never overflow
   a_pop_err: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (count_ff != 2'd0) && (q0_ff == CMD_POP) &&
       (rsp_status != STATUS_OK)) |->
      ((rsp_pop_value == POP_ERR_VALUE) && (rsp_status != STATUS_OVERFLOW)))
      else $error("bad pop error response");

   // Stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(rsp_status) && $stable(rsp_pop_value)))
      else $error("response changed while stalled");
endmodule

bind shared_array_multi_stack_unit sams_checker u_sams_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .req_command   (req_bus.command),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_status    (rsp_bus.status),
   .rsp_pop_value (rsp_bus.pop_value)
);
